### rtl/core/joystick_window_to_segments_top_defines.svh
// assertion macros for the joystick window to segments block
`ifndef JOYSTICK_WINDOW_TO_SEGMENTS_TOP_DEFINES_SVH
`define JOYSTICK_WINDOW_TO_SEGMENTS_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define JWS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("joystick block assertion failed");

// next-cycle implication, disabled during reset
`define JWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("joystick block assertion failed");

`endif

### rtl/core/jws_pkg.sv
// types and constants shared by the joystick window to segments block
`timescale 1ns / 1ps

package jws_pkg;

   localparam int SAMPLE_W    = 12;
   localparam int MAX_SAMPLES = 64;
   localparam int WIN_CNT_W   = 7;
   localparam int WIN_SUM_W   = SAMPLE_W + WIN_CNT_W;

   localparam logic [SAMPLE_W-1:0] CENTER_DEFAULT = 12'd2048;
   localparam logic [3:0]          DP_ALL         = 4'hF;

   localparam logic [6:0] SEG_A = 7'h01;
   localparam logic [6:0] SEG_B = 7'h02;
   localparam logic [6:0] SEG_C = 7'h04;
   localparam logic [6:0] SEG_D = 7'h08;
   localparam logic [6:0] SEG_E = 7'h10;
   localparam logic [6:0] SEG_F = 7'h20;
   localparam logic [6:0] SEG_G = 7'h40;

   localparam logic [2:0] POS_OUTER_A  = 3'd0;
   localparam logic [2:0] POS_MID_A    = 3'd1;
   localparam logic [2:0] POS_INNER_A  = 3'd2;
   localparam logic [2:0] POS_CENTER   = 3'd3;
   localparam logic [2:0] POS_INNER_B  = 3'd4;
   localparam logic [2:0] POS_MID_B    = 3'd5;
   localparam logic [2:0] POS_OUTER_B  = 3'd6;

   localparam logic [1:0] REGION_LOW    = 2'd0;
   localparam logic [1:0] REGION_CENTER = 2'd1;
   localparam logic [1:0] REGION_HIGH   = 2'd2;

   localparam logic [2:0] CSR_DEAD_ZONE          = 3'd0;
   localparam logic [2:0] CSR_MID_THRESHOLD      = 3'd1;
   localparam logic [2:0] CSR_OUTER_THRESHOLD    = 3'd2;
   localparam logic [2:0] CSR_SWITCH_HIGH_NEEDED = 3'd3;
   localparam logic [2:0] CSR_X_LOW_IS_LEFT      = 3'd4;
   localparam logic [2:0] CSR_Y_HIGH_IS_UP       = 3'd5;

   typedef struct packed {
      logic                cmd;
      logic [SAMPLE_W-1:0] x_sample;
      logic                x_done;
      logic [SAMPLE_W-1:0] y_sample;
      logic                y_done;
      logic                switch_level;
   } req_type;

   typedef struct packed {
      logic [6:0] digit0_segments;
      logic [6:0] digit1_segments;
      logic [6:0] digit2_segments;
      logic [6:0] digit3_segments;
      logic [3:0] decimal_points;
      logic [2:0] horiz_pos;
      logic [1:0] vert_zone;
   } rsp_type;

   typedef struct packed {
      logic [10:0] dead_zone;
      logic [11:0] mid_threshold;
      logic [11:0] outer_threshold;
      logic [6:0]  switch_high_needed;
      logic        x_low_is_left;
      logic        y_high_is_up;
   } cfg_type;

   typedef struct packed {
      logic                 cmd;
      logic [WIN_SUM_W-1:0] x_sum;
      logic [WIN_CNT_W-1:0] x_count;
      logic [WIN_SUM_W-1:0] y_sum;
      logic [WIN_CNT_W-1:0] y_count;
      logic [WIN_CNT_W-1:0] switch_high_count;
   } window_type;

endpackage

### rtl/core/jws_front.sv
// front end: accepts sample beats and accumulates one window
`timescale 1ns / 1ps

module jws_front #(
   parameter int SAMPLES     = 8,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  jws_pkg::req_type     req_data,
   output logic                 win_valid,
   input  logic                 win_ready,
   output jws_pkg::window_type  win_data
);
   import jws_pkg::*;

   localparam int CNT_W = $clog2(SAMPLES + 1);
   localparam int SUM_W = SAMPLE_W + CNT_W;
   localparam int IDX_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam logic [SAMPLE_W-1:0] SMASK =
      (SAMPLE_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << SAMPLE_BITS) - 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES - 1);

   logic [SUM_W-1:0] x_sum_ff, x_sum_in, y_sum_ff, y_sum_in;
   logic [CNT_W-1:0] x_cnt_ff, x_cnt_in, y_cnt_ff, y_cnt_in, sw_cnt_ff, sw_cnt_in;
   logic             x_stop_ff, x_stop_in, y_stop_ff, y_stop_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             accept, last, x_take, y_take;

   assign req_ready = win_ready;
   assign accept    = req_valid && win_ready;
   assign last      = (idx_ff == LAST_IDX);
   assign win_valid = accept && last;
   assign x_take    = !x_stop_ff && req_data.x_done;
   assign y_take    = !y_stop_ff && req_data.y_done;

   logic [SUM_W-1:0] x_sum_nx, y_sum_nx;
   logic [CNT_W-1:0] x_cnt_nx, y_cnt_nx, sw_cnt_nx;

   always_comb begin
      x_sum_nx  = x_sum_ff + (x_take ? SUM_W'(req_data.x_sample & SMASK) : '0);
      y_sum_nx  = y_sum_ff + (y_take ? SUM_W'(req_data.y_sample & SMASK) : '0);
      x_cnt_nx  = x_cnt_ff + CNT_W'(x_take);
      y_cnt_nx  = y_cnt_ff + CNT_W'(y_take);
      sw_cnt_nx = sw_cnt_ff + CNT_W'(req_data.switch_level);

      win_data.cmd               = req_data.cmd;
      win_data.x_sum             = WIN_SUM_W'(x_sum_nx);
      win_data.x_count           = WIN_CNT_W'(x_cnt_nx);
      win_data.y_sum             = WIN_SUM_W'(y_sum_nx);
      win_data.y_count           = WIN_CNT_W'(y_cnt_nx);
      win_data.switch_high_count = WIN_CNT_W'(sw_cnt_nx);

      x_sum_in  = x_sum_ff;
      y_sum_in  = y_sum_ff;
      x_cnt_in  = x_cnt_ff;
      y_cnt_in  = y_cnt_ff;
      sw_cnt_in = sw_cnt_ff;
      x_stop_in = x_stop_ff;
      y_stop_in = y_stop_ff;
      idx_in    = idx_ff;
      if (accept) begin
         if (last) begin
            x_sum_in  = '0;
            y_sum_in  = '0;
            x_cnt_in  = '0;
            y_cnt_in  = '0;
            sw_cnt_in = '0;
            x_stop_in = 1'b0;
            y_stop_in = 1'b0;
            idx_in    = '0;
         end else begin
            x_sum_in  = x_sum_nx;
            y_sum_in  = y_sum_nx;
            x_cnt_in  = x_cnt_nx;
            y_cnt_in  = y_cnt_nx;
            sw_cnt_in = sw_cnt_nx;
            x_stop_in = x_stop_ff || !req_data.x_done;
            y_stop_in = y_stop_ff || !req_data.y_done;
            idx_in    = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_sum_ff  <= '0;
         y_sum_ff  <= '0;
         x_cnt_ff  <= '0;
         y_cnt_ff  <= '0;
         sw_cnt_ff <= '0;
         x_stop_ff <= 1'b0;
         y_stop_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         x_sum_ff  <= x_sum_in;
         y_sum_ff  <= y_sum_in;
         x_cnt_ff  <= x_cnt_in;
         y_cnt_ff  <= y_cnt_in;
         sw_cnt_ff <= sw_cnt_in;
         x_stop_ff <= x_stop_in;
         y_stop_ff <= y_stop_in;
         idx_ff    <= idx_in;
      end
   end

endmodule

### rtl/core/jws_queue.sv
// two-entry queue of window summaries between front and back
`timescale 1ns / 1ps

module jws_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  jws_pkg::window_type  push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output jws_pkg::window_type  pop_data
);
   import jws_pkg::*;

   window_type  entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/core/jws_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module jws_div #(
   parameter int DVD_W = 16,
   parameter int DVS_W = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             busy,
   output logic [DVD_W-1:0] quotient
);

   localparam int ST_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [ST_W-1:0]  step_ff, step_in;
   logic             busy_ff, busy_in;
   logic [DVS_W:0]   trial;

   assign busy     = busy_ff;
   assign quotient = quo_ff;
   assign trial    = {rem_ff, quo_ff[DVD_W-1]};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = ST_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DVS_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = DVS_W'(trial);
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         busy_in = (step_ff != ST_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

endmodule

### rtl/core/jws_back.sv
// back end: window averages, centers, classification and result register
`timescale 1ns / 1ps

module jws_back #(
   parameter int SAMPLES = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  jws_pkg::cfg_type     cfg,
   input  logic                 win_valid,
   output logic                 win_ready,
   input  jws_pkg::window_type  win_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output jws_pkg::rsp_type     rsp_data
);
   import jws_pkg::*;

   localparam int CNT_W = $clog2(SAMPLES + 1);
   localparam int SUM_W = SAMPLE_W + CNT_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic                 cmd_ff, cmd_in;
   logic [CNT_W-1:0]     x_cnt_ff, x_cnt_in, y_cnt_ff, y_cnt_in;
   logic [WIN_CNT_W-1:0] sw_cnt_ff, sw_cnt_in;
   logic [SAMPLE_W-1:0]  last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic [SAMPLE_W-1:0]  center_x_ff, center_x_in, center_y_ff, center_y_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 start, x_busy, y_busy;
   logic [SUM_W-1:0]     x_quo, y_quo;
   logic [SAMPLE_W-1:0]  x_avg, y_avg;
   logic                 slot_free;

   logic signed [13:0]   dx, dy, s_dead, s_mid, s_outer;
   logic [2:0]           xp;
   logic [1:0]           yr, up_code, down_code;
   logic [6:0]           lp, rp, vb;
   rsp_type              result;

   assign win_ready = (state_ff == ST_IDLE);
   assign start     = win_valid && win_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   jws_div #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .dividend (win_data.x_sum[SUM_W-1:0]),
      .divisor  (win_data.x_count[CNT_W-1:0]),
      .busy     (x_busy),
      .quotient (x_quo)
   );

   jws_div #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .dividend (win_data.y_sum[SUM_W-1:0]),
      .divisor  (win_data.y_count[CNT_W-1:0]),
      .busy     (y_busy),
      .quotient (y_quo)
   );

   // empty axis falls back to the default center or the last average
   always_comb begin
      if (x_cnt_ff == '0) begin
         x_avg = cmd_ff ? CENTER_DEFAULT : last_x_ff;
      end else begin
         x_avg = SAMPLE_W'(x_quo);
      end
      if (y_cnt_ff == '0) begin
         y_avg = cmd_ff ? CENTER_DEFAULT : last_y_ff;
      end else begin
         y_avg = SAMPLE_W'(y_quo);
      end
   end

   // classification from registered averages and centers
   always_comb begin
      s_dead  = $signed({3'b000, cfg.dead_zone});
      s_mid   = $signed({2'b00, cfg.mid_threshold});
      s_outer = $signed({2'b00, cfg.outer_threshold});
      dx      = $signed({2'b00, last_x_ff}) - $signed({2'b00, center_x_ff});
      dy      = $signed({2'b00, last_y_ff}) - $signed({2'b00, center_y_ff});
      if (cfg.x_low_is_left) begin
         dx = -dx;
      end

      if (dx >= s_outer) begin
         xp = POS_OUTER_A;
      end else if (dx >= s_mid) begin
         xp = POS_MID_A;
      end else if (dx > s_dead) begin
         xp = POS_INNER_A;
      end else if (dx <= -s_outer) begin
         xp = POS_OUTER_B;
      end else if (dx <= -s_mid) begin
         xp = POS_MID_B;
      end else if (dx < -s_dead) begin
         xp = POS_INNER_B;
      end else begin
         xp = POS_CENTER;
      end

      if (dy < -s_dead) begin
         yr = REGION_LOW;
      end else if (dy > s_dead) begin
         yr = REGION_HIGH;
      end else begin
         yr = REGION_CENTER;
      end

      up_code   = cfg.y_high_is_up ? REGION_HIGH : REGION_LOW;
      down_code = cfg.y_high_is_up ? REGION_LOW : REGION_HIGH;
      if (yr == up_code) begin
         lp = SEG_F;
         rp = SEG_B;
         vb = SEG_A;
      end else if (yr == down_code) begin
         lp = SEG_E;
         rp = SEG_C;
         vb = SEG_D;
      end else begin
         lp = SEG_E | SEG_F;
         rp = SEG_B | SEG_C;
         vb = SEG_G;
      end

      result = '0;
      case (xp)
         POS_OUTER_A: result.digit0_segments = lp | vb;
         POS_MID_A:   result.digit0_segments = rp | vb;
         POS_INNER_A: result.digit1_segments = lp | vb;
         POS_CENTER: begin
            result.digit1_segments = rp | vb;
            result.digit2_segments = lp | vb;
         end
         POS_INNER_B: result.digit2_segments = rp | vb;
         POS_MID_B:   result.digit3_segments = lp | vb;
         default:     result.digit3_segments = rp | vb;
      endcase
      result.decimal_points = (sw_cnt_ff < cfg.switch_high_needed) ? DP_ALL : 4'h0;
      result.horiz_pos      = xp;
      result.vert_zone      = yr;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      x_cnt_in     = x_cnt_ff;
      y_cnt_in     = y_cnt_ff;
      sw_cnt_in    = sw_cnt_ff;
      last_x_in    = last_x_ff;
      last_y_in    = last_y_ff;
      center_x_in  = center_x_ff;
      center_y_in  = center_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in    = win_data.cmd;
               x_cnt_in  = win_data.x_count[CNT_W-1:0];
               y_cnt_in  = win_data.y_count[CNT_W-1:0];
               sw_cnt_in = win_data.switch_high_count;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!x_busy && !y_busy) begin
               last_x_in = x_avg;
               last_y_in = y_avg;
               if (cmd_ff) begin
                  center_x_in = x_avg;
                  center_y_in = y_avg;
                  state_in    = ST_IDLE;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      x_cnt_ff    <= x_cnt_in;
      y_cnt_ff    <= y_cnt_in;
      sw_cnt_ff   <= sw_cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_x_ff    <= CENTER_DEFAULT;
         last_y_ff    <= CENTER_DEFAULT;
         center_x_ff  <= CENTER_DEFAULT;
         center_y_ff  <= CENTER_DEFAULT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         center_x_ff  <= center_x_in;
         center_y_ff  <= center_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/core/joystick_window_to_segments_top.sv
// top level of the joystick window to seven-segment block
`timescale 1ns / 1ps

// Joystick window to seven-segment indicator.
// req channel: one joystick sample beat per accepted handshake; SAMPLES beats
// make a window, and the cmd bit of the last beat picks calibrate or run.
// rsp channel: one beat per run window with four digit patterns, decimal
// points, X position and Y region; calibrate windows only update the centers
// and last averages. csr channel: register index and data, always ready; it
// must be written only while idle, which the block itself does not enforce.
// The front accepts one beat per cycle while the queue has room and hands a
// window summary to a two-entry queue. The back divides both axis sums in
// parallel, one quotient bit per cycle; a run window takes it from idle
// through the divide and emit states, a calibrate window goes from divide
// straight back to idle. The back takes a new window only in idle, so the
// front goes on accepting beats while the queue has room. Reset clears the
// window, sets both centers and last averages to 2048 and loads the register
// defaults. A stalled rsp holds its beat; the back then waits and the queue
// and front stall once the queue is full.

module joystick_window_to_segments_top #(
   parameter int SAMPLES     = 8,
   parameter int SAMPLE_BITS = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  jws_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output jws_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [11:0]      csr_data
);
   import jws_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       fq_valid, fq_ready, qb_valid, qb_ready;
   window_type fq_data, qb_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DEAD_ZONE:          cfg_in.dead_zone          = csr_data[10:0];
            CSR_MID_THRESHOLD:      cfg_in.mid_threshold      = csr_data;
            CSR_OUTER_THRESHOLD:    cfg_in.outer_threshold    = csr_data;
            CSR_SWITCH_HIGH_NEEDED: cfg_in.switch_high_needed = csr_data[6:0];
            CSR_X_LOW_IS_LEFT:      cfg_in.x_low_is_left      = csr_data[0];
            CSR_Y_HIGH_IS_UP:       cfg_in.y_high_is_up       = csr_data[0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dead_zone          <= 11'd512;
         cfg_ff.mid_threshold      <= 12'd640;
         cfg_ff.outer_threshold    <= 12'd768;
         cfg_ff.switch_high_needed <= 7'd5;
         cfg_ff.x_low_is_left      <= 1'b0;
         cfg_ff.y_high_is_up       <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   jws_front #(.SAMPLES(SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .win_valid (fq_valid),
      .win_ready (fq_ready),
      .win_data  (fq_data)
   );

   jws_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   jws_back #(.SAMPLES(SAMPLES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .win_valid (qb_valid),
      .win_ready (qb_ready),
      .win_data  (qb_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/core/jws_checker.sv
// port-level checker for the joystick window to segments block
`timescale 1ns / 1ps
`include "joystick_window_to_segments_top_defines.svh"

module jws_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input jws_pkg::rsp_type rsp_data
);
   import jws_pkg::*;

   `JWS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `JWS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data))
   `JWS_ASSERT_IMPLY(a_dp_all_or_none, clock, reset, rsp_valid, rsp_data.decimal_points == DP_ALL || rsp_data.decimal_points == 4'h0)
   `JWS_ASSERT_IMPLY(a_center_two_digits, clock, reset, rsp_valid && rsp_data.horiz_pos == POS_CENTER, rsp_data.digit1_segments != 7'h00 && rsp_data.digit2_segments != 7'h00 && rsp_data.digit0_segments == 7'h00 && rsp_data.digit3_segments == 7'h00)

endmodule

bind joystick_window_to_segments_top jws_checker u_jws_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### tb/sv/joystick_window_to_segments_top_tb.sv
// self-checking testbench for the joystick window to seven-segment block
`timescale 1ns / 1ps

module joystick_window_to_segments_top_tb;
   import jws_pkg::*;

   localparam int WINDOW_LEN    = 8;
   localparam int SETTLE_CYCLES = 80;
   localparam logic CMD_RUN       = 1'b0;
   localparam logic CMD_CALIBRATE = 1'b1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = CSR_DEAD_ZONE;
   logic [11:0] csr_data = '0;

   // register copies
   logic [10:0] cfg_dead_zone = 11'd512;
   logic [11:0] cfg_mid_threshold = 12'd640;
   logic [11:0] cfg_outer_threshold = 12'd768;
   logic [6:0]  cfg_switch_high_needed = 7'd5;
   logic        cfg_x_low_is_left = 1'b0;
   logic        cfg_y_high_is_up = 1'b1;

   // window accumulation
   int unsigned x_acc = 0, y_acc = 0;
   int          x_n = 0, y_n = 0, switch_highs = 0, beat_in_window = 0;
   bit          x_halted = 0, y_halted = 0;
   logic [11:0] prev_x_avg = CENTER_DEFAULT, prev_y_avg = CENTER_DEFAULT;
   logic [11:0] center_x = CENTER_DEFAULT, center_y = CENTER_DEFAULT;

   rsp_type pending_displays[$];
   int      error_count = 0;
   int      beats_sent = 0, displays_checked = 0, calibrations = 0;
   bit      quiet_run = 0;
   int      rsp_hold = 0;

   joystick_window_to_segments_top #(
      .SAMPLES     (WINDOW_LEN),
      .SAMPLE_BITS (SAMPLE_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("timeout waiting for the block");
      $display("*** FAILED ***");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $realtime, what);
      error_count++;
   endtask

   function automatic logic [2:0] horizontal_position(logic [11:0] avg, logic [11:0] ctr);
      int d;
      d = int'(avg) - int'(ctr);
      if (cfg_x_low_is_left) d = -d;
      if (d >= int'(cfg_outer_threshold)) return POS_OUTER_A;
      if (d >= int'(cfg_mid_threshold)) return POS_MID_A;
      if (d > int'(cfg_dead_zone)) return POS_INNER_A;
      if (d <= -int'(cfg_outer_threshold)) return POS_OUTER_B;
      if (d <= -int'(cfg_mid_threshold)) return POS_MID_B;
      if (d < -int'(cfg_dead_zone)) return POS_INNER_B;
      return POS_CENTER;
   endfunction

   function automatic logic [1:0] vertical_region(logic [11:0] avg, logic [11:0] ctr);
      int d;
      d = int'(avg) - int'(ctr);
      if (d < -int'(cfg_dead_zone)) return REGION_LOW;
      if (d > int'(cfg_dead_zone)) return REGION_HIGH;
      return REGION_CENTER;
   endfunction

   function automatic rsp_type display_for(logic [2:0] xp, logic [1:0] yr, bit pressed);
      rsp_type    r;
      logic [6:0] lp, rp, vb;
      logic [1:0] up_region, down_region;
      up_region = cfg_y_high_is_up ? REGION_HIGH : REGION_LOW;
      down_region = cfg_y_high_is_up ? REGION_LOW : REGION_HIGH;
      if (yr == up_region) begin
         lp = SEG_F; rp = SEG_B; vb = SEG_A;
      end else if (yr == down_region) begin
         lp = SEG_E; rp = SEG_C; vb = SEG_D;
      end else begin
         lp = SEG_E | SEG_F; rp = SEG_B | SEG_C; vb = SEG_G;
      end
      r = '0;
      case (xp)
         POS_OUTER_A: r.digit0_segments = lp | vb;
         POS_MID_A:   r.digit0_segments = rp | vb;
         POS_INNER_A: r.digit1_segments = lp | vb;
         POS_CENTER: begin
            r.digit1_segments = rp | vb;
            r.digit2_segments = lp | vb;
         end
         POS_INNER_B: r.digit2_segments = rp | vb;
         POS_MID_B:   r.digit3_segments = lp | vb;
         default:     r.digit3_segments = rp | vb;
      endcase
      r.decimal_points = pressed ? DP_ALL : 4'h0;
      r.horiz_pos = xp;
      r.vert_zone = yr;
      return r;
   endfunction

   // folds one accepted beat into the window, queues a display at run window end
   task automatic absorb_sample(input req_type b);
      bit pressed;
      beats_sent++;
      if (!x_halted) begin
         if (b.x_done) begin
            x_acc += b.x_sample;
            x_n++;
         end else x_halted = 1;
      end
      if (!y_halted) begin
         if (b.y_done) begin
            y_acc += b.y_sample;
            y_n++;
         end else y_halted = 1;
      end
      if (b.switch_level) switch_highs++;
      beat_in_window++;
      if (beat_in_window < WINDOW_LEN) return;
      if (b.cmd == CMD_CALIBRATE) begin
         prev_x_avg = (x_n == 0) ? CENTER_DEFAULT : 12'(x_acc / x_n);
         prev_y_avg = (y_n == 0) ? CENTER_DEFAULT : 12'(y_acc / y_n);
         center_x = prev_x_avg;
         center_y = prev_y_avg;
         calibrations++;
      end else begin
         if (x_n != 0) prev_x_avg = 12'(x_acc / x_n);
         if (y_n != 0) prev_y_avg = 12'(y_acc / y_n);
         pressed = switch_highs < int'(cfg_switch_high_needed);
         pending_displays.push_back(display_for(horizontal_position(prev_x_avg, center_x),
                                                vertical_region(prev_y_avg, center_y),
                                                pressed));
      end
      x_acc = 0; y_acc = 0; x_n = 0; y_n = 0;
      x_halted = 0; y_halted = 0;
      switch_highs = 0; beat_in_window = 0;
   endtask

   function automatic int pace();
      return quiet_run ? 0 : $urandom_range(0, 16);
   endfunction

   // called at a falling edge, returns at the falling edge after the beat is taken
   task automatic send_beat(input req_type b, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      absorb_sample(b);
      @(negedge clock);
   endtask

   task automatic wait_display_idle();
      int n;
      req_valid <= 1'b0;
      for (n = 0; n < 20000 && pending_displays.size() != 0; n++) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [11:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_DEAD_ZONE:          cfg_dead_zone = val[10:0];
         CSR_MID_THRESHOLD:      cfg_mid_threshold = val;
         CSR_OUTER_THRESHOLD:    cfg_outer_threshold = val;
         CSR_SWITCH_HIGH_NEEDED: cfg_switch_high_needed = val[6:0];
         CSR_X_LOW_IS_LEFT:      cfg_x_low_is_left = val[0];
         CSR_Y_HIGH_IS_UP:       cfg_y_high_is_up = val[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic write_settings(input int dz, input int mid, input int outer,
                                 input int shn, input int xl, input int yu);
      wait_display_idle();
      write_register(CSR_DEAD_ZONE, 12'(dz));
      write_register(CSR_MID_THRESHOLD, 12'(mid));
      write_register(CSR_OUTER_THRESHOLD, 12'(outer));
      write_register(CSR_SWITCH_HIGH_NEEDED, 12'(shn));
      write_register(CSR_X_LOW_IS_LEFT, 12'(xl));
      write_register(CSR_Y_HIGH_IS_UP, 12'(yu));
      csr_valid <= 1'b0;
   endtask

   function automatic logic [11:0] clip_sample(int v);
      if (v < 0) return 12'd0;
      if (v > 4095) return 12'd4095;
      return 12'(v);
   endfunction

   function automatic req_type make_beat(logic cmd, int xs, logic xd, int ys, logic yd,
                                         logic sw);
      req_type b;
      b.cmd = cmd;
      b.x_sample = 12'(xs);
      b.x_done = xd;
      b.y_sample = 12'(ys);
      b.y_done = yd;
      b.switch_level = sw;
      return b;
   endfunction

   // run windows mostly aim near the center plus or minus one of the thresholds, else at a random level or offset
   function automatic int pick_level(logic [11:0] ctr, bit calibrate);
      int offset;
      if (calibrate)
         return ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 4095))
                                            : 1748 + int'($urandom_range(0, 600));
      case ($urandom_range(0, 4))
         0: return int'($urandom_range(0, 4095));
         1: offset = int'(cfg_dead_zone);
         2: offset = int'(cfg_mid_threshold);
         3: offset = int'(cfg_outer_threshold);
         default: offset = int'($urandom_range(0, 2500));
      endcase
      offset = offset + int'($urandom_range(0, 4)) - 2;
      if ($urandom_range(0, 1) == 1) offset = -offset;
      return int'(ctr) + offset;
   endfunction

   task automatic send_random_window();
      req_type b;
      bit      calibrate;
      int      x_stop, y_stop, highs, jitter, x_base, y_base, k;
      calibrate = ($urandom_range(0, 4) == 0);
      quiet_run = ($urandom_range(0, 3) == 0);
      x_stop = ($urandom_range(0, 2) == 0) ? $urandom_range(0, WINDOW_LEN - 1) : WINDOW_LEN;
      y_stop = ($urandom_range(0, 2) == 0) ? $urandom_range(0, WINDOW_LEN - 1) : WINDOW_LEN;
      highs = $urandom_range(0, WINDOW_LEN);
      jitter = ($urandom_range(0, 1) == 0) ? 0 : 16;
      x_base = pick_level(center_x, calibrate);
      y_base = pick_level(center_y, calibrate);
      for (k = 0; k < WINDOW_LEN; k++) begin
         if (k == WINDOW_LEN - 1) b.cmd = calibrate ? CMD_CALIBRATE : CMD_RUN;
         else b.cmd = 1'($urandom_range(0, 1));
         if (jitter != 0 && $urandom_range(0, 7) == 0) begin
            b.x_sample = 12'($urandom);
            b.y_sample = 12'($urandom);
         end else begin
            b.x_sample = clip_sample(x_base + int'($urandom_range(0, 2 * jitter)) - jitter);
            b.y_sample = clip_sample(y_base + int'($urandom_range(0, 2 * jitter)) - jitter);
         end
         b.x_done = (k < x_stop) ? 1'b1 : ((k == x_stop) ? 1'b0 : 1'($urandom_range(0, 1)));
         b.y_done = (k < y_stop) ? 1'b1 : ((k == y_stop) ? 1'b0 : 1'($urandom_range(0, 1)));
         b.switch_level = ($urandom_range(1, WINDOW_LEN) <= highs);
         send_beat(b, pace());
      end
   endtask

   // full-scale run, calibrate with empty and partial axes, run with empty Y
   task automatic test_directed_windows();
      int k;
      quiet_run = 0;
      for (k = 0; k < WINDOW_LEN; k++)
         send_beat(make_beat((k == WINDOW_LEN - 1) ? CMD_RUN : 1'(k % 2),
                             4095, 1'b1, 4095, 1'b1, 1'b1), pace());
      for (k = 0; k < WINDOW_LEN; k++)
         send_beat(make_beat((k == WINDOW_LEN - 1) ? CMD_CALIBRATE : CMD_RUN,
                             12'hAAA, 1'(k != 0), 0, 1'(k != 5), 1'(k % 2)), pace());
      for (k = 0; k < WINDOW_LEN; k++)
         send_beat(make_beat(CMD_RUN, 0, 1'b1, 4095, 1'(k != 0), 1'b0), pace());
   endtask

   task automatic test_extreme_settings();
      int w;
      write_settings(0, 0, 0, 0, 1, 0);
      for (w = 0; w < 10; w++) send_random_window();
      write_settings(2047, 4095, 4095, 64, 0, 1);
      for (w = 0; w < 10; w++) send_random_window();
      // thresholds in reverse order of size
      write_settings(900, 300, 100, 8, 1, 1);
      for (w = 0; w < 10; w++) send_random_window();
      write_settings(100, 1500, 1000, 9, 0, 0);
      for (w = 0; w < 10; w++) send_random_window();
   endtask

   task automatic test_random_traffic();
      int w;
      write_settings(512, 640, 768, 5, 0, 1);
      for (w = 0; w < 96; w++) begin
         if (w % 24 == 23)
            write_settings($urandom_range(0, 1200), $urandom_range(0, 2000),
                           $urandom_range(0, 2500), $urandom_range(0, 9),
                           $urandom_range(0, 1), $urandom_range(0, 1));
         send_random_window();
      end
   endtask

   always @(negedge clock) begin
      rsp_ready <= (rsp_hold == 0);
      if (rsp_hold > 0) rsp_hold--;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_hold = quiet_run ? 0 : $urandom_range(0, 16);
         if (pending_displays.size() == 0) begin
            report_mismatch($sformatf("display beat with none expected: %h", rsp_data));
         end else begin
            want = pending_displays.pop_front();
            displays_checked++;
            if (rsp_data.digit0_segments !== want.digit0_segments)
               report_mismatch($sformatf("digit0 got %h want %h",
                                         rsp_data.digit0_segments, want.digit0_segments));
            if (rsp_data.digit1_segments !== want.digit1_segments)
               report_mismatch($sformatf("digit1 got %h want %h",
                                         rsp_data.digit1_segments, want.digit1_segments));
            if (rsp_data.digit2_segments !== want.digit2_segments)
               report_mismatch($sformatf("digit2 got %h want %h",
                                         rsp_data.digit2_segments, want.digit2_segments));
            if (rsp_data.digit3_segments !== want.digit3_segments)
               report_mismatch($sformatf("digit3 got %h want %h",
                                         rsp_data.digit3_segments, want.digit3_segments));
            if (rsp_data.decimal_points !== want.decimal_points)
               report_mismatch($sformatf("decimal points got %h want %h",
                                         rsp_data.decimal_points, want.decimal_points));
            if (rsp_data.horiz_pos !== want.horiz_pos)
               report_mismatch($sformatf("x position got %0d want %0d",
                                         rsp_data.horiz_pos, want.horiz_pos));
            if (rsp_data.vert_zone !== want.vert_zone)
               report_mismatch($sformatf("y region got %0d want %0d",
                                         rsp_data.vert_zone, want.vert_zone));
         end
      end
   end

   initial begin
      reset = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_windows();
      test_extreme_settings();
      test_random_traffic();
      wait_display_idle();
      $display("sent %0d sample beats in %0d windows, %0d of them calibrations",
               beats_sent, beats_sent / WINDOW_LEN, calibrations);
      $display("checked %0d display beats across extreme and random register settings",
               displays_checked);
      if (pending_displays.size() != 0)
         report_mismatch($sformatf("%0d display beats never arrived", pending_displays.size()));
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
